/* rtl/tlb_fifo_lru_lookup_unit_defines.svh */
// assertion macros used by the tlb lookup top level
// expects i_clk and i_rst_n in the scope of every use
`ifndef TLB_FIFO_LRU_LOOKUP_UNIT_DEFINES_SVH
`define TLB_FIFO_LRU_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TFL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TFL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tfl_pkg.sv */
// shared types and constants of the tlb lookup unit
// no dependencies
`timescale 1ns / 1ps

package tfl_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int NUM_ENTRIES_RST = 32;

    localparam int PID_W   = 16;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 20;
    localparam int CFG_W   = 6;
    localparam int ENTRY_W = PID_W + PAGE_W + FRAME_W;

    // register indexes of the configuration port
    localparam logic REG_NUM_ENTRIES = 1'b0;
    localparam logic REG_POLICY      = 1'b1;

    // command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [PAGE_W-1:0]  page;
        logic [PID_W-1:0]   pid;
    } t_entry;

    // per-cell update command
    typedef struct packed {
        logic shift;   // take the entry of the next newer cell
        logic load;    // take the entry on the broadcast bus
    } t_cell_ctl;

endpackage

/* rtl/tfl_cell.sv */
// one slot of the age-ordered tlb chain
// depends on tfl_pkg
`timescale 1ns / 1ps

module tfl_cell (
    input  logic                        i_clk,
    input  tfl_pkg::t_cell_ctl          i_ctl,
    input  tfl_pkg::t_entry             i_bus,
    input  tfl_pkg::t_entry             i_nbr,
    input  logic [tfl_pkg::PID_W-1:0]   i_key_pid,
    input  logic [tfl_pkg::PAGE_W-1:0]  i_key_page,
    output tfl_pkg::t_entry             o_entry,
    output logic                        o_match
);

    tfl_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_entry <= i_bus;
        end else if (i_ctl.shift) begin
            r_entry <= i_nbr;
        end
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry.pid == i_key_pid) && (r_entry.page == i_key_page);

endmodule

/* rtl/tlb_fifo_lru_lookup_unit.sv */
// top level of the fully associative tlb with fifo or lru ordering
// depends on tfl_pkg, tfl_cell and tlb_fifo_lru_lookup_unit_defines.svh
`timescale 1ns / 1ps
`include "tlb_fifo_lru_lookup_unit_defines.svh"

// usage
//   input words arrive on s_axis: tuser is the command (lookup or load),
//   tdata carries pid, page and frame. every word gives exactly one result
//   word on m_axis: tuser holds hit and replaced, tdata the frame number
//   (zero on a miss and for a load).
//   entries live in a row of MAX_ENTRIES cells, oldest in cell 0. a hit
//   under lru and an eviction on a full load shift the cells above the
//   vacated slot down by one, and the moved or new entry lands on top.
//   steps: a word is taken only in idle, so a new word waits until the last
//   one is through. the cells compare the key in parallel (registered match
//   vector), the oldest match is picked (registered one-hot and thermometer),
//   and the shift plus the result write happen in the last step.
//   a stalled receiver holds the result in the output register; the block
//   waits in the last step until the register frees, then goes idle.
//   a synchronous low reset empties the table (fill count zero), sets the
//   capacity to 32 (clipped to MAX_ENTRIES) and the policy to fifo.
//   configuration writes take effect at once; a smaller capacity drops the
//   newest entries. capacity zero turns the table off.

module tlb_fifo_lru_lookup_unit #(
    parameter int MAX_ENTRIES = tfl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [tfl_pkg::CFG_W-1:0]  i_cfg_data,
    // input words
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [55:0]                s_axis_tdata,   // pid, page, frame
    input  logic                       s_axis_tuser,   // cmd
    // result words
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata,   // frame_out, zero pad
    output logic [1:0]                 m_axis_tuser    // hit, replaced
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int CAP_RST = (tfl_pkg::NUM_ENTRIES_RST > MAX_ENTRIES) ?
                             MAX_ENTRIES : tfl_pkg::NUM_ENTRIES_RST;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MATCH = 4'b0010,
        ST_PICK  = 4'b0100,
        ST_APPLY = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_cap, n_cap;
    logic [CW-1:0]               r_fill;
    logic                        r_policy;

    // captured input word
    logic                        r_cmd;
    tfl_pkg::t_entry             r_key;

    logic [MAX_ENTRIES-1:0]      r_match;
    logic [MAX_ENTRIES-1:0]      r_first;
    logic [MAX_ENTRIES-1:0]      r_ge;

    logic                        r_out_valid;
    logic [tfl_pkg::FRAME_W-1:0] r_out_frame;
    logic                        r_out_hit;
    logic                        r_out_repl;

    // cell row
    tfl_pkg::t_entry             w_entry [MAX_ENTRIES];
    tfl_pkg::t_cell_ctl          w_ctl   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]      w_match;
    logic [MAX_ENTRIES-1:0]      w_filled;
    tfl_pkg::t_entry             w_bus;
    tfl_pkg::t_entry             w_hit_entry;

    logic                        w_out_free;
    logic                        w_is_load;
    logic                        w_hit;
    logic                        w_full;
    logic                        w_do_load;
    logic                        w_do_upd;
    logic [CW-1:0]               w_tgt_full;
    logic [EW-1:0]               w_tgt;
    logic [MAX_ENTRIES-1:0]      w_shift_base;
    logic [MAX_ENTRIES-1:0]      w_low;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
            tfl_pkg::t_entry w_nbr;
            if (gi == MAX_ENTRIES - 1) begin : g_top
                assign w_nbr = '0;
            end else begin : g_mid
                assign w_nbr = w_entry[gi+1];
            end

            assign w_filled[gi] = CW'(gi) < r_fill;
            assign w_ctl[gi].load  = w_do_upd && (EW'(gi) == w_tgt);
            assign w_ctl[gi].shift = w_do_upd && w_shift_base[gi] && (EW'(gi) < w_tgt);

            tfl_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl[gi]),
                .i_bus      (w_bus),
                .i_nbr      (w_nbr),
                .i_key_pid  (r_key.pid),
                .i_key_page (r_key.page),
                .o_entry    (w_entry[gi]),
                .o_match    (w_match[gi])
            );
        end
    endgenerate

    // one-hot select of the oldest matching cell
    always_comb begin
        w_hit_entry = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            w_hit_entry = tfl_pkg::t_entry'(w_hit_entry |
                          (w_entry[i] & {tfl_pkg::ENTRY_W{r_first[i]}}));
        end
    end

    assign w_low = r_match & (~r_match + 1'b1);

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_is_load  = (r_cmd == tfl_pkg::CMD_LOAD);
    assign w_hit      = !w_is_load && (|r_first);
    assign w_full     = (r_fill >= r_cap);
    assign w_do_load  = w_is_load && (r_cap != '0);
    assign w_do_upd   = (r_state == ST_APPLY) && w_out_free &&
                        (w_do_load || (w_hit && (r_policy == tfl_pkg::POLICY_LRU)));

    // landing slot: top filled cell when something is removed, else next free
    assign w_tgt_full   = (w_do_load && !w_full) ? r_fill : (r_fill - 1'b1);
    assign w_tgt        = EW'(w_tgt_full);
    // an eviction shifts from cell 0, an lru hit from the hit cell,
    // a load into a free slot shifts nothing
    assign w_shift_base = w_is_load ? {MAX_ENTRIES{w_full}} : r_ge;
    assign w_bus        = w_is_load ? r_key : w_hit_entry;

    always_comb begin
        if (int'(i_cfg_data) > MAX_ENTRIES) begin
            n_cap = CW'(MAX_ENTRIES);
        end else begin
            n_cap = CW'(i_cfg_data);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) n_state = ST_MATCH;
            end
            ST_MATCH: n_state = ST_PICK;
            ST_PICK:  n_state = ST_APPLY;
            ST_APPLY: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CW'(CAP_RST);
            r_fill      <= '0;
            r_policy    <= tfl_pkg::POLICY_FIFO;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tfl_pkg::REG_NUM_ENTRIES: begin
                        r_cap <= n_cap;
                        if (r_fill > n_cap) r_fill <= n_cap;
                    end
                    tfl_pkg::REG_POLICY: r_policy <= i_cfg_data[0];
                    default: ;
                endcase
            end else if (w_do_upd && w_is_load && !w_full) begin
                r_fill <= r_fill + 1'b1;
            end

            if ((r_state == ST_APPLY) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd       <= s_axis_tuser;
            r_key.pid   <= s_axis_tdata[15:0];
            r_key.page  <= s_axis_tdata[35:16];
            r_key.frame <= s_axis_tdata[55:36];
        end
        if (r_state == ST_MATCH) begin
            r_match <= w_match & w_filled;
        end
        if (r_state == ST_PICK) begin
            r_first <= w_low;
            r_ge    <= ~(w_low - 1'b1);
        end
        if ((r_state == ST_APPLY) && w_out_free) begin
            r_out_hit   <= w_hit;
            r_out_frame <= w_hit ? w_hit_entry.frame : '0;
            r_out_repl  <= w_do_load && w_full;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24 - tfl_pkg::FRAME_W){1'b0}}, r_out_frame};
    assign m_axis_tuser  = {r_out_repl, r_out_hit};

    `TFL_ASSERT_NOW(a_fill_le_cap, 1'b1, r_fill <= r_cap, "fill count above capacity")
    `TFL_ASSERT_NOW(a_first_onehot, r_state == ST_APPLY, $onehot0(r_first),
        "more than one cell picked")
    `TFL_ASSERT_NOW(a_hit_no_repl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]),
        "result flags both hit and replaced")
    `TFL_ASSERT_NEXT(a_accept_to_match, s_axis_tvalid && s_axis_tready,
        r_state == ST_MATCH && !s_axis_tready, "accepted word did not start a compare")

endmodule
